/* rtl/uint_to_decimal_text_assert.svh */
// Assertion macros shared by the number-to-text RTL.
`ifndef UINT_TO_DECIMAL_TEXT_ASSERT_SVH
`define UINT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/utdt_pkg.sv */
// Package: widths, character codes and control structs of the number-to-text block.
`timescale 1ns / 1ps
package utdt_pkg;

  localparam int VALUE_BITS = 64;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int SIZE_W     = 8;
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 5;
  localparam int NUM_DIGITS = 20;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] TRUNC_MARK = 8'd60;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic emit;
  } utdt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic emit_last;
    logic out_free;
  } utdt_stat_t;

endpackage

/* rtl/utdt_num_if.sv */
// Interface: input channel carrying one number and its buffer size.
`timescale 1ns / 1ps
interface utdt_num_if
  import utdt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [SIZE_W-1:0]     buffer_size;

  modport source (output valid, value, buffer_size, input ready);
  modport sink   (input valid, value, buffer_size, output ready);
endinterface

/* rtl/utdt_text_if.sv */
// Interface: output channel carrying one character of the rendered text.
`timescale 1ns / 1ps
interface utdt_text_if
  import utdt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic [POS_W-1:0]  position;
  logic              written;
  logic [POS_W-1:0]  text_length;
  logic              is_last;

  modport source (output valid, character, position, written, text_length, is_last,
                  input ready);
  modport sink   (input valid, character, position, written, text_length, is_last,
                  output ready);
endinterface

/* rtl/uint_to_decimal_text.sv */
// Top level: renders an unsigned number as a run of decimal characters.
`timescale 1ns / 1ps
//
//  channel | role | payload
//  --------+------+---------------------------------------------------
//  number  | sink | value (64b), buffer_size (8b)
//  text    | src  | character, position, written, text_length, is_last
//
//  One number takes a load, 64 shift-add-3 steps, a digit count and then
//  one cycle per character word (up to 21) while the text channel is not stalled.
//  The datapath runs the 64-step conversion loop.
//  Reset (synchronous, active high) returns the controller to idle and drops
//  any held output word. A stalled text channel holds the current word and
//  pauses emission; the next number is taken once the last word is queued.
module uint_to_decimal_text
  import utdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  utdt_num_if.sink    number,
  utdt_text_if.source text
);

  utdt_cmd_t  cmd;
  utdt_stat_t stat;
  logic       in_ready;

  assign number.ready = in_ready;

  // Controller: owns the sequence, sees only the input handshake and status.
  utdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: conversion registers, digit count and the output word register.
  utdt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .value       (number.value),
    .buffer_size (number.buffer_size),
    .out_valid   (text.valid),
    .out_ready   (text.ready),
    .character   (text.character),
    .position    (text.position),
    .written     (text.written),
    .text_length (text.text_length),
    .is_last     (text.is_last)
  );

endmodule

/* rtl/utdt_ctrl.sv */
// Controller: sequences load, conversion, digit count and character emission.
`timescale 1ns / 1ps
module utdt_ctrl
  import utdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  utdt_stat_t stat,
  output utdt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    COUNT,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CONV;
        end
      end
      CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_next = COUNT;
        end
      end
      COUNT: begin
        cmd.count  = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "uint_to_decimal_text_assert.svh"

  `UTDT_ASSERT_NEXT(a_load_starts_conv, clk, rst, cmd.load, state == CONV, "load did not start conversion")
  `UTDT_ASSERT_NOW(a_step_only_conv, clk, rst, cmd.step || cmd.emit, !in_ready, "work while ready")
  `UTDT_ASSERT_NEXT(a_last_returns_idle, clk, rst, cmd.emit && stat.emit_last, in_ready, "no idle after last")

endmodule

/* rtl/utdt_datapath.sv */
// Datapath: shift-add-3 binary to BCD, digit count and output word register.
`timescale 1ns / 1ps
module utdt_datapath
  import utdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  utdt_cmd_t             cmd,
  output utdt_stat_t            stat,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [SIZE_W-1:0]     buffer_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     character,
  output logic [POS_W-1:0]      position,
  output logic                  written,
  output logic [POS_W-1:0]      text_length,
  output logic                  is_last
);

  logic [VALUE_BITS-1:0] val_sr;
  logic [SIZE_W-1:0]     size_r;
  logic [3:0]            bcd [NUM_DIGITS];
  logic [3:0]            bcd_adj [NUM_DIGITS];
  logic [3:0]            bcd_next [NUM_DIGITS];
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      t_r;
  logic                  trunc_r;
  logic [POS_W-1:0]      n_digits;
  logic [SIZE_W-1:0]     size_m1;
  logic [POS_W-1:0]      t_calc;
  logic [POS_W-1:0]      dig_idx;
  logic [CHAR_W-1:0]     char_sel;

  // One shift-add-3 step: correct every digit, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
    bcd_next[0] = {bcd_adj[0][2:0], val_sr[VALUE_BITS-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  // Digit count: highest nonzero digit, zero counts as one digit.
  always_comb begin
    n_digits = POS_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        n_digits = POS_W'(i + 1);
      end
    end
  end

  assign size_m1 = size_r - SIZE_W'(1);

  always_comb begin
    if (size_r < SIZE_W'(2)) begin
      t_calc = '0;
    end else if (SIZE_W'(n_digits) < size_m1) begin
      t_calc = n_digits;
    end else begin
      t_calc = size_m1[POS_W-1:0];
    end
  end

  assign dig_idx = t_r - pos - POS_W'(1);

  always_comb begin
    if (pos == t_r) begin
      char_sel = NUL_CHAR;
    end else if ((pos == '0) && trunc_r) begin
      char_sel = TRUNC_MARK;
    end else begin
      char_sel = ASCII_ZERO + CHAR_W'(bcd[dig_idx]);
    end
  end

  assign stat.conv_done = (bit_cnt == BIT_CNT_W'(VALUE_BITS - 1));
  assign stat.emit_last = (pos == t_r);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_sr  <= value;
      size_r  <= buffer_size;
      bit_cnt <= '0;
      pos     <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (cmd.step) begin
      val_sr  <= {val_sr[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd[i] <= bcd_next[i];
      end
    end
    if (cmd.count) begin
      t_r     <= t_calc;
      trunc_r <= (t_calc < n_digits);
    end
    if (cmd.emit) begin
      character   <= char_sel;
      position    <= pos;
      written     <= (size_r != '0);
      text_length <= t_r;
      is_last     <= (pos == t_r);
      pos         <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`include "uint_to_decimal_text_assert.svh"

  `UTDT_ASSERT_NOW(a_emit_into_free, clk, rst, cmd.emit, stat.out_free, "emit over a held word")
  `UTDT_ASSERT_NOW(a_last_at_length, clk, rst, out_valid, is_last == (position == text_length), "last not at length")
  `UTDT_ASSERT_NOW(a_nul_only_last, clk, rst, out_valid, (character == NUL_CHAR) == is_last, "terminator misplaced")

endmodule
